### hw/rtl/mtis_pkg.sv
package mtis_pkg;

  // Fixed field widths
  localparam int SAMPLE_W  = 12;
  localparam int COEF_W    = 18;
  localparam int OUT_W     = 18;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int ACC_W     = PROD_W + 4;
  localparam int CFG_IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEF   = 5;
  localparam int ADC_BITS_DEF = 12;

  // Coefficient reset values (Q1.16)
  localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_PRIOR_RST = 18'sd0;
  localparam logic signed [COEF_W-1:0] COEF_FB_RST    = 18'sd0;

  // Output saturation limits (Q13.4)
  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED_NOW   = 2'd0,
    REG_FEED_PRIOR = 2'd1,
    REG_FEEDBACK   = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_MAC,
    ST_ROUND
  } state_e;

  // Multiplier operand pair
  typedef enum logic [1:0] {
    MUL_NOW,
    MUL_PRIOR,
    MUL_FB
  } mul_sel_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_SH,
    ACC_ADD_SH,
    ACC_SUB
  } acc_op_e;

  // Sequencer controls for the filter datapath
  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     commit;
  } iir_ctrl_t;

endpackage

### hw/rtl/mtis_if.sv
interface mtis_in_if;
  logic                          valid;
  logic                          ready;
  logic [mtis_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface mtis_out_if;
  logic                              valid;
  logic                              ready;
  logic [mtis_pkg::SAMPLE_W-1:0]     median_value;
  logic signed [mtis_pkg::OUT_W-1:0] smoothed_value;
  logic                              saturated_flag;

  modport source (output valid, output median_value, output smoothed_value,
                  output saturated_flag, input ready);
  modport sink   (input valid, input median_value, input smoothed_value,
                  input saturated_flag, output ready);
endinterface

### hw/rtl/mtis_median.sv
module mtis_median #(
  parameter int WINDOW = mtis_pkg::WINDOW_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [mtis_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic [$clog2(WINDOW)-1:0]     cand_idx_i,
  output logic [mtis_pkg::SAMPLE_W-1:0] cand_o,
  output logic                          hit_o
);
  import mtis_pkg::*;

  localparam int IdxW = $clog2(WINDOW);
  localparam int CntW = $clog2(WINDOW + 1);
  localparam logic [CntW-1:0] MidRank = CntW'(WINDOW / 2);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);

  logic [SAMPLE_W-1:0] store_q [WINDOW];
  logic [IdxW-1:0]     slot_q;
  logic [CntW-1:0]     rank;

  // Circular window, oldest entry overwritten
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) store_q[i] <= '0;
      slot_q <= '0;
    end else if (wr_en_i) begin
      store_q[slot_q] <= wr_data_i;
      slot_q <= (slot_q == LastIdx) ? '0 : slot_q + 1'b1;
    end
  end

  assign cand_o = store_q[cand_idx_i];

  // Stable rank of the candidate: smaller entries, plus equal ones at lower index
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((store_q[j] < cand_o) ||
          ((store_q[j] == cand_o) && (IdxW'(j) < cand_idx_i))) begin
        rank = rank + 1'b1;
      end
    end
  end

  assign hit_o = (rank == MidRank);

endmodule

### hw/rtl/mtis_iir.sv
module mtis_iir (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtis_pkg::iir_ctrl_t               ctrl_i,
  input  logic signed [mtis_pkg::COEF_W-1:0] coef_now_i,
  input  logic signed [mtis_pkg::COEF_W-1:0] coef_prior_i,
  input  logic signed [mtis_pkg::COEF_W-1:0] coef_fb_i,
  input  logic [mtis_pkg::SAMPLE_W-1:0]     med_i,
  output logic signed [mtis_pkg::OUT_W-1:0] y_o,
  output logic                              sat_o
);
  import mtis_pkg::*;

  localparam int RndW = ACC_W - 16;

  logic [SAMPLE_W-1:0]      prior_med_q;
  logic signed [OUT_W-1:0]  prior_out_q;
  logic signed [COEF_W-1:0] op_a;
  logic signed [COEF_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [RndW-1:0]   y_full;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (ctrl_i.mul_sel)
      MUL_NOW: begin
        op_a = coef_now_i;
        op_b = signed'({{(COEF_W-SAMPLE_W){1'b0}}, med_i});
      end
      MUL_PRIOR: begin
        op_a = coef_prior_i;
        op_b = signed'({{(COEF_W-SAMPLE_W){1'b0}}, prior_med_q});
      end
      MUL_FB: begin
        op_a = coef_fb_i;
        op_b = prior_out_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Product register
  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  assign prod_ext = ACC_W'(prod_q);

  // Accumulator: feedforward terms scaled to 2^-20, feedback subtracted
  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_HOLD:    acc_d = acc_q;
      ACC_LOAD_SH: acc_d = prod_ext <<< 4;
      ACC_ADD_SH:  acc_d = acc_q + (prod_ext <<< 4);
      ACC_SUB:     acc_d = acc_q - prod_ext;
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Round half up to Q13.4 and clip
  assign acc_rnd = acc_q + ACC_W'(32768);
  assign y_full  = RndW'(acc_rnd >>> 16);

  always_comb begin
    if (y_full > RndW'(OUT_MAX)) begin
      y_o   = OUT_MAX;
      sat_o = 1'b1;
    end else if (y_full < RndW'(OUT_MIN)) begin
      y_o   = OUT_MIN;
      sat_o = 1'b1;
    end else begin
      y_o   = OUT_W'(y_full);
      sat_o = 1'b0;
    end
  end

  // Filter history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_med_q <= '0;
      prior_out_q <= '0;
    end else if (ctrl_i.commit) begin
      prior_med_q <= med_i;
      prior_out_q <= y_o;
    end
  end

endmodule

### hw/rtl/median_then_iir_smoother_core.sv
// Each accepted sample runs through the rank scan, the multiply-accumulate steps and
// the round step before the next one is taken; the rank scan tries one
// window entry per cycle, then one shared 18x18 multiplier runs three products.
// Input is taken only while the sequencer is idle; a result still waiting in the
// output register holds the sequencer in its round step until the receiver takes it.
// Reset (async, active low) zeroes window, slot and history; a0 = 1.0, a1 = b1 = 0.
module median_then_iir_smoother_core #(
  parameter int WINDOW   = mtis_pkg::WINDOW_DEF,
  parameter int ADC_BITS = mtis_pkg::ADC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mtis_in_if.sink                          in_ch,
  mtis_out_if.source                       out_ch,
  input  logic                             cfg_we_i,
  input  logic [mtis_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mtis_pkg::COEF_W-1:0]      cfg_data_i
);
  import mtis_pkg::*;

  localparam int IdxW       = $clog2(WINDOW);
  localparam int SampleBits = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SampleMask = SAMPLE_W'((33'd1 << SampleBits) - 33'd1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);
  localparam logic [1:0] MacLast = 2'd3;

  state_e state_q, state_d;
  logic [IdxW-1:0]          rank_idx_q;
  logic [1:0]               mac_step_q;
  logic [SAMPLE_W-1:0]      med_q;
  logic signed [COEF_W-1:0] coef_now_q, coef_prior_q, coef_fb_q;

  logic                     in_xfer;
  logic                     out_free;
  logic                     store_wr;
  logic                     load_out;
  logic [SAMPLE_W-1:0]      cand;
  logic                     rank_hit;
  iir_ctrl_t                iir_ctrl;
  logic signed [OUT_W-1:0]  y;
  logic                     sat;

  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_med_q;
  logic signed [OUT_W-1:0]  out_y_q;
  logic                     out_sat_q;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;

  // Coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_now_q   <= COEF_NOW_RST;
      coef_prior_q <= COEF_PRIOR_RST;
      coef_fb_q    <= COEF_FB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FEED_NOW:   coef_now_q   <= signed'(cfg_data_i);
        REG_FEED_PRIOR: coef_prior_q <= signed'(cfg_data_i);
        REG_FEEDBACK:   coef_fb_q    <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_ch.valid) state_d = ST_RANK;
      ST_RANK:  if (rank_hit || rank_idx_q == LastIdx) state_d = ST_MAC;
      ST_MAC:   if (mac_step_q == MacLast) state_d = ST_ROUND;
      ST_ROUND: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready      = 1'b0;
    store_wr         = 1'b0;
    load_out         = 1'b0;
    iir_ctrl.mul_sel = MUL_NOW;
    iir_ctrl.acc_op  = ACC_HOLD;
    iir_ctrl.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        store_wr    = in_ch.valid;
      end
      ST_RANK: ;
      ST_MAC: begin
        unique case (mac_step_q)
          2'd0: iir_ctrl.mul_sel = MUL_NOW;
          2'd1: begin
            iir_ctrl.mul_sel = MUL_PRIOR;
            iir_ctrl.acc_op  = ACC_LOAD_SH;
          end
          2'd2: begin
            iir_ctrl.mul_sel = MUL_FB;
            iir_ctrl.acc_op  = ACC_ADD_SH;
          end
          default: iir_ctrl.acc_op = ACC_SUB;
        endcase
      end
      ST_ROUND: begin
        load_out        = out_free;
        iir_ctrl.commit = out_free;
      end
      default: ;
    endcase
  end

  // State and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rank_idx_q <= '0;
      mac_step_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RANK) rank_idx_q <= rank_idx_q + 1'b1;
      else                    rank_idx_q <= '0;
      if (state_q == ST_MAC)  mac_step_q <= mac_step_q + 1'b1;
      else                    mac_step_q <= '0;
    end
  end

  // Median capture when the scan finds the middle rank
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RANK && rank_hit) med_q <= cand;
  end

  mtis_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (store_wr),
    .wr_data_i  (in_ch.adc_sample & SampleMask),
    .cand_idx_i (rank_idx_q),
    .cand_o     (cand),
    .hit_o      (rank_hit)
  );

  mtis_iir u_iir (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (iir_ctrl),
    .coef_now_i   (coef_now_q),
    .coef_prior_i (coef_prior_q),
    .coef_fb_i    (coef_fb_q),
    .med_i        (med_q),
    .y_o          (y),
    .sat_o        (sat)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_med_q <= med_q;
      out_y_q   <= y;
      out_sat_q <= sat;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.median_value   = out_med_q;
  assign out_ch.smoothed_value = out_y_q;
  assign out_ch.saturated_flag = out_sat_q;

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == ST_RANK)
    else $error("input transfer did not start the rank scan");

  a_last_cand_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK && rank_idx_q == LastIdx) |-> rank_hit)
    else $error("rank scan found no median");

  a_result_from_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_ROUND)
    else $error("result appeared outside the round step");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |-> (out_y_q == OUT_MAX || out_y_q == OUT_MIN))
    else $error("saturation flag without clipped value");

endmodule

### dv/median_then_iir_smoother_core_tb.sv
`timescale 1ns / 1ps

module median_then_iir_smoother_core_tb;
  import mtis_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int LIMIT = 400000;
  localparam int TAIL = WIN + 20;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int NUM_PHASES = 8;
  // Index past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [SAMPLE_W-1:0]     median;
    logic signed [OUT_W-1:0] smooth;
    logic                    sat;
  } filt_out_t;

  // Tracks window, filter history and coefficients; holds awaited results
  class median_iir_scoreboard;
    logic [SAMPLE_W-1:0] win [WIN];
    int                  slot;
    longint              prior_med;
    longint              prior_out;
    longint              a_now;
    longint              a_prior;
    longint              b_fb;
    filt_out_t           awaited [$];
    int                  errors;

    function new();
      foreach (win[i]) win[i] = '0;
      slot = 0;
      prior_med = 0;
      prior_out = 0;
      a_now = COEF_NOW_RST;
      a_prior = COEF_PRIOR_RST;
      b_fb = COEF_FB_RST;
      errors = 0;
    endfunction

    function void set_coef(logic [CFG_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      case (idx)
        REG_FEED_NOW:   a_now = val;
        REG_FEED_PRIOR: a_prior = val;
        REG_FEEDBACK:   b_fb = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Accepted sample: update window, rank it, run the filter step
    function void note_sample(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] ranked [WIN];
      logic [SAMPLE_W-1:0] key;
      int                  i;
      int                  j;
      longint              med;
      longint              acc;
      longint              y;
      filt_out_t           e;
      win[slot] = s;
      slot = (slot + 1) % WIN;
      ranked = win;
      for (i = 1; i < WIN; i++) begin
        key = ranked[i];
        j = i;
        while (j > 0 && ranked[j-1] > key) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = key;
      end
      med = ranked[WIN/2];
      // feedforward in 2^-16 units, scaled to 2^-20, feedback already in 2^-20
      acc = (a_now * med + a_prior * prior_med) * 16 - b_fb * prior_out;
      // round half up to Q13.4
      y = (acc + 32768) >>> 16;
      e.sat = 1'b0;
      if (y > longint'(OUT_MAX)) begin
        y = OUT_MAX;
        e.sat = 1'b1;
      end else if (y < longint'(OUT_MIN)) begin
        y = OUT_MIN;
        e.sat = 1'b1;
      end
      e.median = med[SAMPLE_W-1:0];
      e.smooth = y[OUT_W-1:0];
      prior_med = med;
      prior_out = y;
      awaited.push_back(e);
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] m, logic signed [OUT_W-1:0] y,
                               logic sat);
      filt_out_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: median %0d smoothed %0d flag %0b",
                 $time, m, y, sat);
        return;
      end
      e = awaited.pop_front();
      if (m !== e.median) begin
        errors++;
        $display("%0t: median_value expected %0d actual %0d", $time, e.median, m);
      end
      if (y !== e.smooth) begin
        errors++;
        $display("%0t: smoothed_value expected %0d actual %0d", $time, e.smooth, y);
      end
      if (sat !== e.sat) begin
        errors++;
        $display("%0t: saturated_flag expected %0b actual %0b", $time, e.sat, sat);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COEF_W-1:0]    cfg_data_i;

  mtis_in_if  in_ch ();
  mtis_out_if out_ch ();

  median_then_iir_smoother_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  median_iir_scoreboard sb;
  int send_gap_pct = 0;
  int sink_stall_pct = 0;
  int cycles = 0;
  int trend = 2048;

  // Coefficient sets (Q1.16): unity, gentle low-pass, extremes, zero
  int coef_tab [6][3] = '{
    '{65536, 0, 0},
    '{16384, 16384, -32768},
    '{131071, 131071, -131072},
    '{-131072, -131072, 131071},
    '{0, 0, 0},
    '{-131072, 131071, -131072}
  };

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Output monitor; sampled mid-cycle so edge ordering cannot matter
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_result(out_ch.median_value, out_ch.smoothed_value, out_ch.saturated_flag);
    end
  end

  // Slowly drifting signal with spikes, holds and plain noise mixed in
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      trend = trend + int'($urandom_range(0, 80)) - 40;
      if (trend < 0) trend = 0;
      if (trend > 4095) trend = 4095;
      v = trend + int'($urandom_range(0, 16)) - 8;
    end else if (r < 65) begin
      v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
    end else if (r < 75) begin
      v = trend;
    end else begin
      v = $urandom_range(0, 4095);
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // One input transfer, with random idle cycles ahead of it
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_sample <= s;
    do @(negedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
    @(posedge clk_i);
  endtask

  // Stop sending and wait for every awaited result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_coef(idx, val);
    @(posedge clk_i);
  endtask

  task automatic write_coefs(logic [COEF_W-1:0] a0, logic [COEF_W-1:0] a1,
                             logic [COEF_W-1:0] b1);
    write_reg(REG_FEED_NOW, a0);
    write_reg(REG_FEED_PRIOR, a1);
    write_reg(REG_FEEDBACK, b1);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int p;
    int mode;
    sb = new();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_FEED_NOW;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients; reset zeros still sit in the window at first
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2048);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'd4094);
    send_sample(12'd0);
    send_sample(12'd0);

    // Stray write to an unused index, then clip high with maximum gains
    drain();
    write_reg(REG_SPARE, '1);
    write_coefs(18'sd131071, 18'sd131071, -18'sd131072);
    repeat (3) send_sample(12'd4095);

    // Clip the other way with the most negative gains
    drain();
    write_coefs(-18'sd131072, -18'sd131072, 18'sd131071);
    repeat (3) send_sample(12'd4095);
    send_sample(12'd0);

    // Random phases; each starts idle, so coefficients change only there
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p < 6) begin
        write_coefs(COEF_W'(coef_tab[p][0]), COEF_W'(coef_tab[p][1]),
                    COEF_W'(coef_tab[p][2]));
      end else begin
        write_coefs(COEF_W'($urandom_range(0, 262143)), COEF_W'($urandom_range(0, 262143)),
                    COEF_W'($urandom_range(0, 262143)));
      end
      mode = p % 4;
      case (mode)
        0: begin
          send_gap_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 55;
          sink_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          sink_stall_pct = 55;
        end
        default: begin
          send_gap_pct = 12;
          sink_stall_pct = 12;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_sample(next_sample());
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### median_then_iir_smoother_core.f
hw/rtl/mtis_pkg.sv
hw/rtl/mtis_if.sv
hw/rtl/mtis_median.sv
hw/rtl/mtis_iir.sv
hw/rtl/median_then_iir_smoother_core.sv
dv/median_then_iir_smoother_core_tb.sv
